// ----- design/lls_pkg.sv -----
// ----------------------------------------------------------------------------
// lls_pkg
// Shared types, constants and the microcode table of the segment swap block.
// ----------------------------------------------------------------------------
package lls_pkg;

    localparam int ID_W             = 11;
    localparam int MAX_NODES_DEF    = 1024;
    localparam int NODE_COUNT_RESET = 1024;

    typedef logic [ID_W-1:0] t_id;
    typedef logic [1:0]      t_mode;

    localparam t_mode MODE_REBUILD = 2'd0;
    localparam t_mode MODE_SWAP    = 2'd1;
    localparam t_mode MODE_QUERY   = 2'd2;

    // Microcode addresses.
    typedef enum logic [3:0] {
        UP_IDLE,
        UP_SWEEP,
        UP_DONE,
        UP_S_RD1,
        UP_S_RD2,
        UP_S_W1,
        UP_S_W2,
        UP_S_W3,
        UP_S_W4,
        UP_S_W5,
        UP_Q_RD,
        UP_Q_CAP
    } t_upc;

    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_DISPATCH,
        J_SWEEP,
        J_FINISH
    } t_jmp;

    typedef enum logic [3:0] {
        SRC_NONE,
        SRC_S1,
        SRC_E1,
        SRC_S2,
        SRC_E2,
        SRC_B1,
        SRC_A1,
        SRC_B2,
        SRC_A2
    } t_src;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_PAIR,
        WR_COND,
        WR_SWEEP
    } t_wr;

    typedef enum logic [1:0] {
        CAP_NONE,
        CAP_1,
        CAP_2
    } t_cap;

    typedef enum logic [1:0] {
        FR_KEEP,
        FR_ONE,
        FR_SWAP
    } t_front;

    typedef struct packed {
        t_jmp   jmp;
        t_upc   target;
        t_src   rd_next;
        t_src   rd_prev;
        t_wr    wr;
        t_src   wr_left;
        t_src   wr_right;
        t_cap   cap;
        t_front front_op;
        logic   in_ready;
    } t_uword;

    localparam t_uword UW_NOP = '{
        jmp: J_NEXT, target: UP_IDLE, rd_next: SRC_NONE, rd_prev: SRC_NONE,
        wr: WR_NONE, wr_left: SRC_NONE, wr_right: SRC_NONE, cap: CAP_NONE,
        front_op: FR_KEEP, in_ready: 1'b0
    };

    // The control program. A swap reads the four outer links, then relinks
    // the four boundaries and finally closes the gap of adjacent segments.
    function automatic t_uword lls_rom(input t_upc pc);
        t_uword w;
        w = UW_NOP;
        unique case (pc)
            UP_IDLE: begin
                w.jmp      = J_DISPATCH;
                w.in_ready = 1'b1;
            end
            UP_SWEEP: begin
                w.jmp      = J_SWEEP;
                w.wr       = WR_SWEEP;
                w.front_op = FR_ONE;
            end
            UP_DONE: begin
                w.jmp    = J_FINISH;
                w.target = UP_IDLE;
            end
            UP_S_RD1: begin
                w.rd_prev = SRC_S1;
                w.rd_next = SRC_E1;
            end
            UP_S_RD2: begin
                w.rd_prev = SRC_S2;
                w.rd_next = SRC_E2;
                w.cap     = CAP_1;
            end
            UP_S_W1: begin
                w.cap      = CAP_2;
                w.wr       = WR_PAIR;
                w.wr_left  = SRC_B1;
                w.wr_right = SRC_S2;
                w.front_op = FR_SWAP;
            end
            UP_S_W2: begin
                w.wr       = WR_PAIR;
                w.wr_left  = SRC_E2;
                w.wr_right = SRC_A1;
            end
            UP_S_W3: begin
                w.wr       = WR_PAIR;
                w.wr_left  = SRC_B2;
                w.wr_right = SRC_S1;
            end
            UP_S_W4: begin
                w.wr       = WR_PAIR;
                w.wr_left  = SRC_E1;
                w.wr_right = SRC_A2;
            end
            UP_S_W5: begin
                w.wr     = WR_COND;
                w.jmp    = J_GOTO;
                w.target = UP_DONE;
            end
            UP_Q_RD: begin
                w.rd_prev = SRC_S1;
                w.rd_next = SRC_S1;
            end
            UP_Q_CAP: begin
                w.cap    = CAP_1;
                w.jmp    = J_GOTO;
                w.target = UP_DONE;
            end
            default: begin
                w.jmp    = J_GOTO;
                w.target = UP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- design/lls_in_if.sv -----
// ----------------------------------------------------------------------------
// lls_in_if
// Request channel of the segment swap block: valid, ready and one item.
// ----------------------------------------------------------------------------
interface lls_in_if;
    logic          valid;
    logic          ready;
    lls_pkg::t_mode mode;
    lls_pkg::t_id  first_start;
    lls_pkg::t_id  first_end;
    lls_pkg::t_id  second_start;
    lls_pkg::t_id  second_end;

    modport source (output valid, mode, first_start, first_end, second_start,
                    second_end, input ready);
    modport sink   (input valid, mode, first_start, first_end, second_start,
                    second_end, output ready);
endinterface

// ----- design/lls_out_if.sv -----
// ----------------------------------------------------------------------------
// lls_out_if
// Result channel of the segment swap block: valid, ready and one item.
// ----------------------------------------------------------------------------
interface lls_out_if;
    logic         valid;
    logic         ready;
    lls_pkg::t_id head_node;
    lls_pkg::t_id successor;
    lls_pkg::t_id predecessor;

    modport source (output valid, head_node, successor, predecessor, input ready);
    modport sink   (input valid, head_node, successor, predecessor, output ready);
endinterface

// ----- design/linked_list_segment_swap_core.sv -----
// ----------------------------------------------------------------------------
// linked_list_segment_swap_core
// Doubly linked order of node ids kept in successor and predecessor memories.
// ----------------------------------------------------------------------------
// Each request item on i_item carries a mode and four node ids; each one
// produces exactly one result item on o_result with the current head and,
// for a query, the successor and predecessor of the queried node.
// Mode 0 rebuilds the ascending list of node_count nodes, mode 1 swaps two
// segments, mode 2 queries one node, mode 3 changes nothing.
// node_count is to be written through i_cfg_we / i_cfg_data while the block
// idles; the block itself does not enforce this. A small microcode table
// sequences a datapath around two memories, each with one write and one
// registered read port. A swap runs two read steps and five write steps, a
// query a read step and a capture step, and a rebuild a sweep over all
// MAX_NODES entries that writes one entry of both memories per cycle. The
// result item turns valid in the same cycle as the block is ready again.
// After reset the block runs the same sweep as a rebuild, with ready low
// and no result item; configuration writes are still taken.
// A finished result sits in an output register; the next item is accepted
// while it waits, but the following result holds in the last step until
// the receiver takes the earlier one.
// ----------------------------------------------------------------------------
module linked_list_segment_swap_core #(
    parameter int MAX_NODES = lls_pkg::MAX_NODES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  lls_pkg::t_id        i_cfg_data,
    lls_in_if.sink              i_item,
    lls_out_if.source           o_result
);

    localparam int AW = $clog2(MAX_NODES);

    typedef logic [AW-1:0] t_addr;

    localparam t_addr LAST_ADDR = AW'(MAX_NODES - 1);

    // Memories.
    lls_pkg::t_id r_next_mem [MAX_NODES];
    lls_pkg::t_id r_prev_mem [MAX_NODES];
    lls_pkg::t_id r_next_rd, r_prev_rd;

    // Control state.
    lls_pkg::t_upc r_upc, n_upc;
    t_addr         r_sweep, n_sweep;
    logic          r_emit, n_emit;
    logic          r_report, n_report;
    logic          r_out_valid, n_out_valid;
    lls_pkg::t_id  r_front, n_front;
    lls_pkg::t_id  r_node_count;
    lls_pkg::t_id  r_limit, n_limit;

    // Operands and link values read back.
    lls_pkg::t_id r_s1, n_s1, r_e1, n_e1, r_s2, n_s2, r_e2, n_e2;
    lls_pkg::t_id r_b1, n_b1, r_a1, n_a1, r_b2, n_b2, r_a2, n_a2;
    lls_pkg::t_id r_out_head, n_out_head;
    lls_pkg::t_id r_out_succ, n_out_succ;
    lls_pkg::t_id r_out_pred, n_out_pred;

    lls_pkg::t_uword uw;
    logic            accept;
    logic            next_we, prev_we;
    t_addr           next_wa, prev_wa, next_ra, prev_ra;
    lls_pkg::t_id    next_wd, prev_wd;
    lls_pkg::t_id    left_id, right_id;
    logic [31:0]     sweep_id, limit_w;

    function automatic lls_pkg::t_id clamp_count(input lls_pkg::t_id nc);
        lls_pkg::t_id c;
        if (nc == '0) begin
            c = lls_pkg::ID_W'(1);
        end else if (32'(nc) > 32'(MAX_NODES)) begin
            c = lls_pkg::ID_W'(MAX_NODES);
        end else begin
            c = nc;
        end
        return c;
    endfunction

    function automatic logic id_ok(input lls_pkg::t_id id);
        return (id != '0) && (32'(id) <= 32'(MAX_NODES));
    endfunction

    function automatic t_addr to_addr(input lls_pkg::t_id id);
        return AW'(id - lls_pkg::ID_W'(1));
    endfunction

    function automatic lls_pkg::t_id pick(
        input lls_pkg::t_src s,
        input lls_pkg::t_id s1, e1, s2, e2, b1, a1, b2, a2
    );
        lls_pkg::t_id v;
        unique case (s)
            lls_pkg::SRC_S1: v = s1;
            lls_pkg::SRC_E1: v = e1;
            lls_pkg::SRC_S2: v = s2;
            lls_pkg::SRC_E2: v = e2;
            lls_pkg::SRC_B1: v = b1;
            lls_pkg::SRC_A1: v = a1;
            lls_pkg::SRC_B2: v = b2;
            lls_pkg::SRC_A2: v = a2;
            default:         v = '0;
        endcase
        return v;
    endfunction

    always_comb begin
        uw = lls_pkg::lls_rom(r_upc);

        n_upc       = r_upc;
        n_sweep     = r_sweep;
        n_emit      = r_emit;
        n_report    = r_report;
        n_out_valid = r_out_valid;
        n_front     = r_front;
        n_limit     = r_limit;
        n_s1        = r_s1;
        n_e1        = r_e1;
        n_s2        = r_s2;
        n_e2        = r_e2;
        n_b1        = r_b1;
        n_a1        = r_a1;
        n_b2        = r_b2;
        n_a2        = r_a2;
        n_out_head  = r_out_head;
        n_out_succ  = r_out_succ;
        n_out_pred  = r_out_pred;

        accept = i_item.valid && uw.in_ready;

        if (r_out_valid && o_result.ready) begin
            n_out_valid = 1'b0;
        end

        // Sequencing.
        unique case (uw.jmp)
            lls_pkg::J_NEXT: n_upc = lls_pkg::t_upc'(4'(r_upc) + 4'd1);
            lls_pkg::J_GOTO: n_upc = uw.target;
            lls_pkg::J_DISPATCH: begin
                if (accept) begin
                    n_s1     = i_item.first_start;
                    n_e1     = i_item.first_end;
                    n_s2     = i_item.second_start;
                    n_e2     = i_item.second_end;
                    n_emit   = 1'b1;
                    n_report = 1'b0;
                    n_sweep  = '0;
                    unique case (i_item.mode)
                        lls_pkg::MODE_REBUILD: begin
                            n_limit = clamp_count(r_node_count);
                            n_upc   = lls_pkg::UP_SWEEP;
                        end
                        lls_pkg::MODE_SWAP: begin
                            if (id_ok(i_item.first_start) && id_ok(i_item.first_end) &&
                                id_ok(i_item.second_start) && id_ok(i_item.second_end)) begin
                                n_upc = lls_pkg::UP_S_RD1;
                            end else begin
                                n_upc = lls_pkg::UP_DONE;
                            end
                        end
                        lls_pkg::MODE_QUERY: begin
                            n_report = id_ok(i_item.first_start);
                            n_upc    = lls_pkg::UP_Q_RD;
                        end
                        default: n_upc = lls_pkg::UP_DONE;
                    endcase
                end
            end
            lls_pkg::J_SWEEP: begin
                if (r_sweep == LAST_ADDR) begin
                    n_sweep = '0;
                    n_upc   = lls_pkg::t_upc'(4'(r_upc) + 4'd1);
                end else begin
                    n_sweep = r_sweep + t_addr'(1);
                end
            end
            lls_pkg::J_FINISH: begin
                // The result waits here while the previous one is still held.
                if (!r_emit || !r_out_valid || o_result.ready) begin
                    if (r_emit) begin
                        n_out_valid = 1'b1;
                        n_out_head  = r_front;
                        n_out_succ  = r_report ? r_a1 : '0;
                        n_out_pred  = r_report ? r_b1 : '0;
                    end
                    n_emit = 1'b0;
                    n_upc  = uw.target;
                end
            end
            default: n_upc = lls_pkg::UP_IDLE;
        endcase

        // Captures of registered read data.
        unique case (uw.cap)
            lls_pkg::CAP_1: begin
                n_b1 = r_prev_rd;
                n_a1 = r_next_rd;
            end
            lls_pkg::CAP_2: begin
                n_b2 = r_prev_rd;
                n_a2 = r_next_rd;
            end
            default: ;
        endcase

        unique case (uw.front_op)
            lls_pkg::FR_ONE: n_front = lls_pkg::ID_W'(1);
            lls_pkg::FR_SWAP: begin
                if (r_s1 == r_front) begin
                    n_front = r_s2;
                end else if (r_s2 == r_front) begin
                    n_front = r_s1;
                end
            end
            default: ;
        endcase

        // Read ports.
        next_ra = to_addr(pick(uw.rd_next, r_s1, r_e1, r_s2, r_e2,
                               r_b1, r_a1, r_b2, r_a2));
        prev_ra = to_addr(pick(uw.rd_prev, r_s1, r_e1, r_s2, r_e2,
                               r_b1, r_a1, r_b2, r_a2));

        // Write ports: a link pair writes next[left] and prev[right].
        left_id  = pick(uw.wr_left, r_s1, r_e1, r_s2, r_e2, r_b1, r_a1, r_b2, r_a2);
        right_id = pick(uw.wr_right, r_s1, r_e1, r_s2, r_e2, r_b1, r_a1, r_b2, r_a2);
        if (uw.wr == lls_pkg::WR_COND) begin
            // Adjacent segments: close the link between them the other way.
            if (r_a1 == r_s2) begin
                left_id  = r_e2;
                right_id = r_s1;
            end else if (r_a2 == r_s1) begin
                left_id  = r_e1;
                right_id = r_s2;
            end else begin
                left_id  = '0;
                right_id = '0;
            end
        end

        sweep_id = 32'(r_sweep) + 32'd1;
        limit_w  = 32'(r_limit);

        if (uw.wr == lls_pkg::WR_SWEEP) begin
            next_we = 1'b1;
            prev_we = 1'b1;
            next_wa = r_sweep;
            prev_wa = r_sweep;
            next_wd = (sweep_id < limit_w) ? lls_pkg::ID_W'(sweep_id + 32'd1) : '0;
            prev_wd = (sweep_id >= 32'd2 && sweep_id <= limit_w) ?
                      lls_pkg::ID_W'(sweep_id - 32'd1) : '0;
        end else begin
            next_we = (uw.wr != lls_pkg::WR_NONE) && (left_id != '0);
            prev_we = (uw.wr != lls_pkg::WR_NONE) && (right_id != '0);
            next_wa = to_addr(left_id);
            prev_wa = to_addr(right_id);
            next_wd = right_id;
            prev_wd = left_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (next_we) begin
            r_next_mem[next_wa] <= next_wd;
        end
        if (prev_we) begin
            r_prev_mem[prev_wa] <= prev_wd;
        end
        r_next_rd <= r_next_mem[next_ra];
        r_prev_rd <= r_prev_mem[prev_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc        <= lls_pkg::UP_SWEEP;
            r_sweep      <= '0;
            r_emit       <= 1'b0;
            r_report     <= 1'b0;
            r_out_valid  <= 1'b0;
            r_front      <= lls_pkg::ID_W'(1);
            r_node_count <= lls_pkg::ID_W'(lls_pkg::NODE_COUNT_RESET);
            r_limit      <= clamp_count(lls_pkg::ID_W'(lls_pkg::NODE_COUNT_RESET));
        end else begin
            r_upc       <= n_upc;
            r_sweep     <= n_sweep;
            r_emit      <= n_emit;
            r_report    <= n_report;
            r_out_valid <= n_out_valid;
            r_front     <= n_front;
            r_limit     <= n_limit;
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1       <= n_s1;
        r_e1       <= n_e1;
        r_s2       <= n_s2;
        r_e2       <= n_e2;
        r_b1       <= n_b1;
        r_a1       <= n_a1;
        r_b2       <= n_b2;
        r_a2       <= n_a2;
        r_out_head <= n_out_head;
        r_out_succ <= n_out_succ;
        r_out_pred <= n_out_pred;
    end

    assign i_item.ready         = uw.in_ready;
    assign o_result.valid       = r_out_valid;
    assign o_result.head_node   = r_out_head;
    assign o_result.successor   = r_out_succ;
    assign o_result.predecessor = r_out_pred;

    // The idle step never touches the link memories.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc == lls_pkg::UP_IDLE) |-> (!next_we && !prev_we))
        else $error("link write while idle");

    // An accepted item always leaves the idle step.
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> (r_upc != lls_pkg::UP_IDLE))
        else $error("accepted item not dispatched");

    // The sweep counter rests at zero outside the sweep.
    a_sweep_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_upc != lls_pkg::UP_SWEEP) |-> (r_sweep == '0))
        else $error("sweep counter not cleared");

    // A result is only loaded from the finishing step.
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_upc) == lls_pkg::UP_DONE))
        else $error("result loaded outside finishing step");

    // The head is always a real node.
    a_front_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front != '0)
        else $error("head register is zero");

endmodule
